### design/cpe_pkg.sv
// ---------------------------------------------------------------------------
// cpe_pkg
// Shared types and constants of the column parabola envelope block.
// ---------------------------------------------------------------------------
package cpe_pkg;

    localparam int PIX_W = 12;
    localparam int POS_W = 6;
    localparam int VAL_W = 24;

    localparam logic [VAL_W-1:0] INF_VAL = '1;

    localparam int PIXELS_DEF     = 4096;
    localparam int MAX_SLICES_DEF = 64;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_QUERY = 1'b1
    } cpe_cmd_t;

    typedef struct packed {
        cpe_cmd_t               command;
        logic [PIX_W-1:0]       pixel;
        logic [POS_W-1:0]       slice_pos;
        logic [VAL_W-1:0]       value;
    } cpe_in_t;

    typedef struct packed {
        logic [VAL_W-1:0]       sq_distance;
        logic                   is_infinite;
    } cpe_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TOP,
        S_PENT,
        S_DIV,
        S_QENT,
        S_QNXT,
        S_RES
    } cpe_state_t;

endpackage

### design/cpe_ram.sv
// ---------------------------------------------------------------------------
// cpe_ram
// Simple dual port synchronous ram, one write and one registered read port.
// ---------------------------------------------------------------------------
module cpe_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/cpe_div.sv
// ---------------------------------------------------------------------------
// cpe_div
// Serial restoring divider, one quotient bit per cycle, floor rounding.
// ---------------------------------------------------------------------------
module cpe_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_W-1:0]        num_abs,
    input  logic                    neg,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] qd_reg, qd_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, qd_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W - 1);
            qd_next   = num_abs;
            rem_next  = '0;
            den_next  = den;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            qd_next  = {qd_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // floor result for a negative numerator
    always_comb
    begin
        if (neg_reg)
        begin
            quot = -($signed(qd_reg) + $signed(NUM_W'(rem_reg != '0)));
        end
        else
        begin
            quot = $signed(qd_reg);
        end
    end

    assign done = done_reg;

endmodule

### design/column_parabola_envelope_top.sv
// ---------------------------------------------------------------------------
// column_parabola_envelope_top
// Per pixel lower envelope of parabolas along z, with push and query beats.
// ---------------------------------------------------------------------------
// After reset the block clears the per pixel top index memory with busy
// high. A push beat is dropped while idle when its pixel or slice is out
// of range. It ends after the top index read when it starts a column or
// carries an infinite value, and after the top entry read when its slice
// does not rise or it replaces an infinite base. Otherwise it runs
// intersections on the serial divider, one divider step per numerator bit
// plus setup and decision each: one for the new entry plus one per popped
// entry. A query beat passes the top index, base entry and result states
// when the column holds a single entry. Otherwise it adds one entry read
// per boundary compared: one per entry walked past, plus one unless the
// walk ends at the top entry. The single entry memory read port sets this.
// Each result is presented for exactly one cycle with result_valid
// and must be taken then; the next beat may be started in that same cycle.
module column_parabola_envelope_top
    import cpe_pkg::*;
#(
    parameter int PIXELS     = PIXELS_DEF,
    parameter int MAX_SLICES = MAX_SLICES_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cpe_pkg::cpe_in_t  item,
    output logic              result_valid,
    output cpe_pkg::cpe_out_t result
);

    localparam int PX_AW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int K_W    = $clog2(MAX_SLICES);
    localparam int ENT_D  = PIXELS * MAX_SLICES;
    localparam int ENT_AW = $clog2(ENT_D);
    localparam int NB     = VAL_W + 2;
    localparam int NUM_W  = NB + FRAC_BITS;
    localparam int BND_W  = NUM_W;
    localparam int DEN_W  = POS_W + 1;
    localparam int ENT_W  = POS_W + BND_W + VAL_W;

    cpe_state_t         state_reg, state_next;
    logic [PX_AW-1:0]   clr_reg, clr_next;
    cpe_cmd_t           cmd_reg, cmd_next;
    logic [PIX_W-1:0]   px_reg, px_next;
    logic [POS_W-1:0]   q_reg, q_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [K_W-1:0]     top_reg, top_next;
    logic               first_reg, first_next;
    logic signed [BND_W-1:0] bnd_reg, bnd_next;
    logic [POS_W-1:0]   cpos_reg, cpos_next;
    logic [VAL_W-1:0]   ch_reg, ch_next;
    logic               inf_reg, inf_next;
    logic               rv_reg, rv_next;
    cpe_out_t           res_reg, res_next;

    // memory ports
    logic               top_we, top_re;
    logic [PX_AW-1:0]   top_waddr, top_raddr;
    logic [K_W-1:0]     top_wdata, top_rdata;
    logic               ent_we, ent_re;
    logic [K_W-1:0]     ent_k;
    logic [ENT_AW-1:0]  ent_addr;
    logic [ENT_W-1:0]   ent_wdata, ent_rdata;

    // divider ports
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_abs;
    logic               div_neg;
    logic [DEN_W-1:0]   div_den;
    logic signed [NUM_W-1:0] div_quot;

    // entry fields and arithmetic
    logic [POS_W-1:0]        e_pos;
    logic signed [BND_W-1:0] e_bnd;
    logic [VAL_W-1:0]        e_h;
    logic [2*POS_W-1:0]      q_sq, v_sq;
    logic signed [NB-1:0]    num_base;
    logic signed [NUM_W-1:0] num_full;
    logic signed [BND_W-1:0] zf;
    logic [K_W:0]            k_inc;
    logic [K_W:0]            k_inc2;
    logic signed [POS_W:0]   delta;
    logic signed [2*POS_W+1:0] dsq;
    logic [VAL_W:0]          dsum;
    logic                    px_ok, pos_ok;

    cpe_ram #(
        .DEPTH (PIXELS),
        .WIDTH (K_W),
        .AW    (PX_AW)
    ) u_top_ram (
        .clk   (clk),
        .we    (top_we),
        .waddr (top_waddr),
        .wdata (top_wdata),
        .re    (top_re),
        .raddr (top_raddr),
        .rdata (top_rdata)
    );

    cpe_ram #(
        .DEPTH (ENT_D),
        .WIDTH (ENT_W),
        .AW    (ENT_AW)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_addr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_addr),
        .rdata (ent_rdata)
    );

    cpe_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_abs (div_abs),
        .neg     (div_neg),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // entry word fields
    assign e_pos = ent_rdata[ENT_W-1 -: POS_W];
    assign e_bnd = $signed(ent_rdata[VAL_W +: BND_W]);
    assign e_h   = ent_rdata[VAL_W-1:0];

    // intersection numerator and denominator
    always_comb
    begin
        q_sq     = q_reg * q_reg;
        v_sq     = e_pos * e_pos;
        num_base = $signed({2'b00, val_reg}) - $signed({2'b00, e_h})
                 + $signed(NB'(q_sq)) - $signed(NB'(v_sq));
        num_full = $signed(NUM_W'(num_base)) <<< FRAC_BITS;
        div_neg  = num_full[NUM_W-1];
        div_abs  = div_neg ? NUM_W'(-num_full) : NUM_W'(num_full);
        div_den  = {q_reg - e_pos, 1'b0};
    end

    // query helpers
    always_comb
    begin
        zf     = $signed(BND_W'(q_reg) << FRAC_BITS);
        k_inc  = (K_W+1)'(k_reg) + (K_W+1)'(1);
        k_inc2 = k_inc + (K_W+1)'(1);
        delta  = $signed({1'b0, q_reg}) - $signed({1'b0, cpos_reg});
        dsq    = delta * delta;
        dsum   = {1'b0, ch_reg} + (VAL_W+1)'($unsigned(dsq));
        px_ok  = 32'(item.pixel) < PIXELS;
        pos_ok = 32'(item.slice_pos) < MAX_SLICES;
    end

    assign ent_addr = ENT_AW'(px_reg) * ENT_AW'(MAX_SLICES) + ENT_AW'(ent_k);

    // next state and memory control
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd_next   = cmd_reg;
        px_next    = px_reg;
        q_next     = q_reg;
        val_next   = val_reg;
        k_next     = k_reg;
        top_next   = top_reg;
        first_next = first_reg;
        bnd_next   = bnd_reg;
        cpos_next  = cpos_reg;
        ch_next    = ch_reg;
        inf_next   = inf_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        top_we     = 1'b0;
        top_re     = 1'b0;
        top_waddr  = PX_AW'(px_reg);
        top_raddr  = PX_AW'(item.pixel);
        top_wdata  = '0;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_k      = k_reg;
        ent_wdata  = {q_reg, BND_W'(0), val_reg};
        div_start  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                top_we    = 1'b1;
                top_waddr = clr_reg;
                clr_next  = clr_reg + PX_AW'(1);
                if (32'(clr_reg) == PIXELS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = item.command;
                    px_next  = item.pixel;
                    q_next   = item.slice_pos;
                    val_next = item.value;
                    inf_next = 1'b0;
                    if (item.command == CMD_PUSH)
                    begin
                        if (px_ok && pos_ok)
                        begin
                            top_re     = 1'b1;
                            state_next = S_TOP;
                        end
                    end
                    else if (px_ok)
                    begin
                        top_re     = 1'b1;
                        state_next = S_TOP;
                    end
                    else
                    begin
                        inf_next   = 1'b1;
                        state_next = S_RES;
                    end
                end
            end
            S_TOP:
            begin
                k_next     = top_rdata;
                top_next   = top_rdata;
                first_next = 1'b1;
                state_next = S_IDLE;
                if (cmd_reg == CMD_QUERY)
                begin
                    k_next     = '0;
                    ent_k      = '0;
                    ent_re     = 1'b1;
                    state_next = S_QENT;
                end
                else if (q_reg == '0)
                begin
                    // new column
                    top_we    = 1'b1;
                    ent_k     = '0;
                    ent_we    = 1'b1;
                    ent_wdata = {POS_W'(0), BND_W'(0), val_reg};
                end
                else if (val_reg != INF_VAL)
                begin
                    ent_k      = top_rdata;
                    ent_re     = 1'b1;
                    state_next = S_PENT;
                end
            end
            S_PENT:
            begin
                bnd_next   = e_bnd;
                first_next = 1'b0;
                if (first_reg && (q_reg <= e_pos))
                begin
                    state_next = S_IDLE;
                end
                else if (first_reg && (k_reg == '0) && (e_h == INF_VAL))
                begin
                    // infinite base is replaced
                    ent_k      = '0;
                    ent_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if ((k_reg != '0) && (div_quot <= bnd_reg))
                    begin
                        // pop and intersect with the entry below
                        k_next     = k_reg - K_W'(1);
                        ent_k      = k_reg - K_W'(1);
                        ent_re     = 1'b1;
                        state_next = S_PENT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (32'(k_inc) < MAX_SLICES)
                        begin
                            ent_k     = k_inc[K_W-1:0];
                            ent_we    = 1'b1;
                            ent_wdata = {q_reg, div_quot, val_reg};
                            top_we    = 1'b1;
                            top_wdata = k_inc[K_W-1:0];
                        end
                    end
                end
            end
            S_QENT:
            begin
                cpos_next = e_pos;
                ch_next   = e_h;
                if ((top_reg == '0) && (e_h == INF_VAL))
                begin
                    inf_next   = 1'b1;
                    state_next = S_RES;
                end
                else if (top_reg != '0)
                begin
                    ent_k      = K_W'(1);
                    ent_re     = 1'b1;
                    state_next = S_QNXT;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_QNXT:
            begin
                state_next = S_RES;
                if (e_bnd < zf)
                begin
                    cpos_next = e_pos;
                    ch_next   = e_h;
                    k_next    = k_inc[K_W-1:0];
                    if (k_inc < (K_W+1)'(top_reg))
                    begin
                        ent_k      = k_inc2[K_W-1:0];
                        ent_re     = 1'b1;
                        state_next = S_QNXT;
                    end
                end
            end
            S_RES:
            begin
                rv_next = 1'b1;
                res_next.is_infinite = inf_reg;
                if (inf_reg || dsum[VAL_W])
                begin
                    res_next.sq_distance = INF_VAL;
                end
                else
                begin
                    res_next.sq_distance = dsum[VAL_W-1:0];
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        px_reg    <= px_next;
        q_reg     <= q_next;
        val_reg   <= val_next;
        k_reg     <= k_next;
        top_reg   <= top_next;
        first_reg <= first_next;
        bnd_reg   <= bnd_next;
        cpos_reg  <= cpos_next;
        ch_reg    <= ch_next;
        inf_reg   <= inf_next;
        res_reg   <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

`ifndef SYNTH
    // a result beat follows only the result state
    a_res_after_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_RES))
        else $error("result beat without result state");

    // queries never write the envelope
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> (cmd_reg == CMD_PUSH))
        else $error("entry write during a query");

    // the divider never starts on a zero divisor
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (div_den != '0))
        else $error("divider started with zero divisor");

    // no beat is taken during the clearing pass
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> busy)
        else $error("not busy while clearing");
`endif

endmodule
